[hdl/nearest_neighbor_image_scaler_unit_assert.svh]
// Assertion macros shared by the scaler modules.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_UNIT_ASSERT_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle whenever ante holds.
`define NNIS_CHECK_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Check that cons holds in the cycle after ante holds.
`define NNIS_CHECK_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define NNIS_CHECK_IMPL(lbl, clk, rstn, ante, cons)
`define NNIS_CHECK_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hdl/nnis_pkg.sv]
`default_nettype none

package nnis_pkg;

	localparam int MAX_SIDE  = 256;
	localparam int SIDE_W    = $clog2(MAX_SIDE);
	localparam int EFF_W     = SIDE_W + 1;
	localparam int ADDR_W    = 2 * SIDE_W;
	localparam int DEPTH     = MAX_SIDE * MAX_SIDE;

	localparam int SRC_W     = 9;
	localparam int TGT_W     = 13;
	localparam int COORD_W   = 12;
	localparam int PIX_W     = 32;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam int EXT_W     = (SRC_W > EFF_W) ? SRC_W : EFF_W;
	localparam int CMP_W     = (COORD_W > EFF_W) ? COORD_W : EFF_W;
	localparam int PROD_W    = COORD_W + EFF_W;
	localparam int NUM_W     = PROD_W + 2;
	localparam int DEN_W     = TGT_W + 1;
	localparam int DSH_W     = DEN_W + SIDE_W;
	localparam int WIDE_W    = (NUM_W > DSH_W) ? NUM_W : DSH_W;
	localparam int CNT_W     = $clog2(SIDE_W + 1);

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_TGT_WIDTH,
		REG_TGT_HEIGHT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_STARTX,
		S_DIVX,
		S_DIVY,
		S_READ,
		S_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic div_start_x;
		logic div_start_y;
		logic latch_x;
		logic latch_y;
		logic mem_rd;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic in_sample;
		logic div_idle;
	} dp_stat_t;

	function automatic logic [EFF_W-1:0] eff_source(input logic [SRC_W-1:0] v);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		if (ext == '0)
			return EFF_W'(1);
		if (ext > EXT_W'(MAX_SIDE))
			return EFF_W'(MAX_SIDE);
		return EFF_W'(ext);
	endfunction

	function automatic logic [TGT_W-1:0] eff_target(input logic [TGT_W-1:0] v);
		return (v == '0) ? TGT_W'(1) : v;
	endfunction

endpackage

`default_nettype wire

[hdl/nnis_req_if.sv]
`default_nettype none

interface nnis_req_if
	import nnis_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic [PIX_W-1:0]   pixel_in;

	modport source (output valid, output cmd, output col, output row, output pixel_in,
		input ready);
	modport sink (input valid, input cmd, input col, input row, input pixel_in,
		output ready);
endinterface

`default_nettype wire

[hdl/nnis_rsp_if.sv]
`default_nettype none

interface nnis_rsp_if
	import nnis_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;

	modport source (output valid, output pixel_out, input ready);
	modport sink (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

[hdl/nnis_div.sv]
`default_nettype none
`include "nearest_neighbor_image_scaler_unit_assert.svh"

module nnis_div
	import nnis_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	output logic                   busy,
	output logic                   ovf,
	output logic [SIDE_W-1:0]      quo
);

	logic [CNT_W-1:0]  cnt_q;
	logic [WIDE_W-1:0] rem_q;
	logic [WIDE_W-1:0] dsh_q;
	logic [SIDE_W-1:0] quo_q;
	logic              ovf_q;
	logic              take;

	assign busy = (cnt_q != '0);
	assign take = (rem_q >= dsh_q);
	assign ovf  = ovf_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(SIDE_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= WIDE_W'(num);
			dsh_q <= WIDE_W'(den) << (SIDE_W - 1);
			ovf_q <= WIDE_W'(num) >= (WIDE_W'(den) << SIDE_W);
			quo_q <= '0;
		end else if (busy) begin
			if (take)
				rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= SIDE_W'({quo_q, take});
		end
	end

	`NNIS_CHECK_NEXT(a_start_loads, clk, arst_n, start, (cnt_q == CNT_W'(SIDE_W)))
	`NNIS_CHECK_NEXT(a_count_down, clk, arst_n, (busy && !start),
		(cnt_q == $past(cnt_q) - CNT_W'(1)))
	`NNIS_CHECK_IMPL(a_rem_bound, clk, arst_n, (busy && !ovf_q),
		((WIDE_W + 1)'(rem_q) < {dsh_q, 1'b0}))

endmodule

`default_nettype wire

[hdl/nnis_dp.sv]
`default_nettype none

module nnis_dp
	import nnis_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire dp_cmd_t              cmd,
	output dp_stat_t                  stat,
	input  wire logic                 req_cmd,
	input  wire logic [COORD_W-1:0]   req_col,
	input  wire logic [COORD_W-1:0]   req_row,
	input  wire logic [PIX_W-1:0]     req_pixel,
	output logic [PIX_W-1:0]          pixel_out
);

	logic [SRC_W-1:0]   src_w_q;
	logic [SRC_W-1:0]   src_h_q;
	logic [TGT_W-1:0]   tgt_w_q;
	logic [TGT_W-1:0]   tgt_h_q;

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [PROD_W-1:0]  prod_x_s1;
	logic [PROD_W-1:0]  prod_y_s1;
	logic [SIDE_W-1:0]  sx_q;
	logic [SIDE_W-1:0]  sy_q;
	logic [PIX_W-1:0]   rd_q;
	logic [PIX_W-1:0]   pixel_out_q;

	logic [PIX_W-1:0]   mem [DEPTH];

	logic [EFF_W-1:0]   sw;
	logic [EFF_W-1:0]   sh;
	logic [TGT_W-1:0]   tw;
	logic [TGT_W-1:0]   th;
	logic [SIDE_W-1:0]  lim_x;
	logic [SIDE_W-1:0]  lim_y;
	logic [NUM_W-1:0]   num_x;
	logic [NUM_W-1:0]   num_y;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic               div_start;
	logic               div_busy;
	logic               div_ovf;
	logic [SIDE_W-1:0]  div_quo;
	logic               load_hit;
	logic [ADDR_W-1:0]  wr_addr;

	assign sw    = eff_source(src_w_q);
	assign sh    = eff_source(src_h_q);
	assign tw    = eff_target(tgt_w_q);
	assign th    = eff_target(tgt_h_q);
	assign lim_x = SIDE_W'(sw - EFF_W'(1));
	assign lim_y = SIDE_W'(sh - EFF_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_W'(MAX_SIDE);
			src_h_q <= SRC_W'(MAX_SIDE);
			tgt_w_q <= TGT_W'(256);
			tgt_h_q <= TGT_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:  src_w_q <= cfg_data[SRC_W-1:0];
				REG_SRC_HEIGHT: src_h_q <= cfg_data[SRC_W-1:0];
				REG_TGT_WIDTH:  tgt_w_q <= cfg_data[TGT_W-1:0];
				REG_TGT_HEIGHT: tgt_h_q <= cfg_data[TGT_W-1:0];
				default: ;
			endcase
		end
	end

	assign load_hit = cmd.capture && (req_cmd == CMD_LOAD)
		&& (CMP_W'(req_col) < CMP_W'(sw)) && (CMP_W'(req_row) < CMP_W'(sh));
	assign wr_addr  = {req_row[SIDE_W-1:0], req_col[SIDE_W-1:0]};

	always_ff @(posedge clk) begin
		if (load_hit)
			mem[wr_addr] <= req_pixel;
		if (cmd.mem_rd)
			rd_q <= mem[{sy_q, sx_q}];
	end

	assign num_x     = NUM_W'({prod_x_s1, 1'b0}) + NUM_W'(tw);
	assign num_y     = NUM_W'({prod_y_s1, 1'b0}) + NUM_W'(th);
	assign div_num   = cmd.div_start_y ? num_y : num_x;
	assign div_den   = cmd.div_start_y ? {th, 1'b0} : {tw, 1'b0};
	assign div_start = cmd.div_start_x || cmd.div_start_y;

	nnis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.ovf    (div_ovf),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			col_q <= req_col;
			row_q <= req_row;
		end
		if (cmd.mul) begin
			prod_x_s1 <= PROD_W'(col_q) * PROD_W'(sw);
			prod_y_s1 <= PROD_W'(row_q) * PROD_W'(sh);
		end
		if (cmd.latch_x)
			sx_q <= (div_ovf || div_quo > lim_x) ? lim_x : div_quo;
		if (cmd.latch_y)
			sy_q <= (div_ovf || div_quo > lim_y) ? lim_y : div_quo;
		if (cmd.out_load)
			pixel_out_q <= rd_q;
	end

	assign stat.in_sample = (req_cmd == CMD_SAMPLE);
	assign stat.div_idle  = !div_busy;
	assign pixel_out      = pixel_out_q;

endmodule

`default_nettype wire

[hdl/nnis_ctrl.sv]
`default_nettype none
`include "nearest_neighbor_image_scaler_unit_assert.svh"

module nnis_ctrl
	import nnis_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && stat.in_sample)
					state_d = S_MUL;
			end
			S_MUL:    state_d = S_STARTX;
			S_STARTX: state_d = S_DIVX;
			S_DIVX: begin
				if (stat.div_idle)
					state_d = S_DIVY;
			end
			S_DIVY: begin
				if (stat.div_idle)
					state_d = S_READ;
			end
			S_READ:   state_d = S_OUT;
			S_OUT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_MUL:    cmd.mul = 1'b1;
			S_STARTX: cmd.div_start_x = 1'b1;
			S_DIVX: begin
				cmd.latch_x     = stat.div_idle;
				cmd.div_start_y = stat.div_idle;
			end
			S_DIVY:   cmd.latch_y = stat.div_idle;
			S_READ:   cmd.mem_rd = 1'b1;
			S_OUT:    cmd.out_load = out_free;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	`NNIS_CHECK_IMPL(a_out_slot_free, clk, arst_n, cmd.out_load, (!out_valid_q || out_ready))
	`NNIS_CHECK_NEXT(a_sample_starts, clk, arst_n, (in_valid && in_ready && stat.in_sample),
		(state_q == S_MUL))
	`NNIS_CHECK_IMPL(a_div_free, clk, arst_n, (cmd.div_start_x || cmd.div_start_y),
		stat.div_idle)

endmodule

`default_nettype wire

[hdl/nearest_neighbor_image_scaler_unit.sv]
// Channel   Dir  Payload                     Accepted when
// req       in   cmd, col, row, pixel_in     req.valid && req.ready
// rsp       out  pixel_out                   rsp.valid && rsp.ready
// cfg       in   cfg_index, cfg_data         cfg_we
//
// A load is taken whenever the controller is idle. A sample runs the multiply, the
// shared restoring divider, run once per axis at one quotient bit per cycle, then the
// frame store read and output load. arst_n clears the controller, divider count and
// output valid and sets the size registers to 256; the frame store is not cleared.
// The output register holds a result while rsp stalls, and req is taken again as
// soon as that result is registered.
`default_nettype none

module nearest_neighbor_image_scaler_unit
	import nnis_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	nnis_req_if.sink                  req,
	nnis_rsp_if.source                rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	nnis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	nnis_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.req_cmd   (req.cmd),
		.req_col   (req.col),
		.req_row   (req.row),
		.req_pixel (req.pixel_in),
		.pixel_out (rsp.pixel_out)
	);

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import nnis_pkg::*;

	class scaler_scoreboard;
		bit [8:0]  src_w;
		bit [8:0]  src_h;
		bit [12:0] tgt_w;
		bit [12:0] tgt_h;
		bit [31:0] frame [DEPTH];
		bit        written [DEPTH];
		bit [31:0] expected_pixels [$];
		int        errors;

		function new();
			src_w = 9'd256;
			src_h = 9'd256;
			tgt_w = 13'd256;
			tgt_h = 13'd256;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, bit [12:0] data);
			case (idx)
			REG_SRC_WIDTH: src_w = data[8:0];
			REG_SRC_HEIGHT: src_h = data[8:0];
			REG_TGT_WIDTH: tgt_w = data;
			REG_TGT_HEIGHT: tgt_h = data;
			default: ;
			endcase
		endfunction

		function int unsigned active_src(bit [8:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_SIDE)
				return MAX_SIDE;
			return v;
		endfunction

		function int unsigned active_tgt(bit [12:0] v);
			return (v == 0) ? 1 : v;
		endfunction

		function int unsigned scale_axis(bit [11:0] d, int unsigned src, int unsigned dst);
			int unsigned s;
			s = (2 * d * src + dst) / (2 * dst);
			return (s > src - 1) ? src - 1 : s;
		endfunction

		function bit [15:0] pixel_addr(bit [11:0] col, bit [11:0] row);
			int unsigned sx;
			int unsigned sy;
			sx = scale_axis(col, active_src(src_w), active_tgt(tgt_w));
			sy = scale_axis(row, active_src(src_h), active_tgt(tgt_h));
			return 16'(sy * MAX_SIDE + sx);
		endfunction

		function void note_input(logic cmd, bit [11:0] col, bit [11:0] row, bit [31:0] pix);
			bit [15:0] a;
			if (cmd == CMD_LOAD) begin
				if (col < active_src(src_w) && row < active_src(src_h)) begin
					a = 16'(row * MAX_SIDE + col);
					frame[a] = pix;
					written[a] = 1'b1;
				end
			end else begin
				expected_pixels.push_back(frame[pixel_addr(col, row)]);
			end
		endfunction

		function void check_result(bit [31:0] got);
			bit [31:0] want;
			if (expected_pixels.size() == 0) begin
				errors++;
				$error("pixel_out: expected none, actual %h", got);
				return;
			end
			want = expected_pixels.pop_front();
			if (got !== want) begin
				errors++;
				$error("pixel_out: expected %h, actual %h", want, got);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	cfg_reg_t           cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	bit                 stall_en = 1'b1;

	nnis_req_if req();
	nnis_rsp_if rsp();

	scaler_scoreboard sb = new();

	nearest_neighbor_image_scaler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
				sb.check_result(rsp.pixel_out);
			rsp.ready <= !(stall_en && $urandom_range(0, 99) < 34);
		end
	end

	task automatic send_item(logic cmd, bit [11:0] col, bit [11:0] row, bit [31:0] pix);
		while (stall_en && $urandom_range(0, 99) < 34) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.col <= col;
		req.row <= row;
		req.pixel_in <= pix;
		do @(posedge clk); while (req.ready !== 1'b1);
		sb.note_input(cmd, col, row, pix);
	endtask

	// load the source pixel first if the mapped entry was never written
	task automatic sample_pixel(bit [11:0] col, bit [11:0] row);
		bit [15:0] a;
		a = sb.pixel_addr(col, row);
		if (!sb.written[a])
			send_item(CMD_LOAD, 12'(a[7:0]), 12'(a[15:8]), $urandom());
		send_item(CMD_SAMPLE, col, row, $urandom());
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_sizes(bit [12:0] sw, bit [12:0] sh, bit [12:0] tw, bit [12:0] th);
		bit [12:0] vals [4];
		settle();
		vals = '{sw, sh, tw, th};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(cfg_reg_t'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(int n);
		int unsigned sw;
		int unsigned sh;
		int unsigned tw;
		int unsigned th;
		bit [11:0] col;
		bit [11:0] row;
		sw = sb.active_src(sb.src_w);
		sh = sb.active_src(sb.src_h);
		tw = sb.active_tgt(sb.tgt_w);
		th = sb.active_tgt(sb.tgt_h);
		if (tw > 4096)
			tw = 4096;
		if (th > 4096)
			th = 4096;
		repeat (n) begin
			if ($urandom_range(0, 99) < 45) begin
				if ($urandom_range(0, 9) == 0) begin
					col = 12'($urandom());
					row = 12'($urandom());
				end else begin
					col = 12'($urandom_range(0, sw - 1));
					row = 12'($urandom_range(0, sh - 1));
				end
				send_item(CMD_LOAD, col, row, $urandom());
			end else begin
				if ($urandom_range(0, 6) == 0) begin
					col = 12'($urandom());
					row = 12'($urandom());
				end else begin
					col = 12'($urandom_range(0, tw - 1));
					row = 12'($urandom_range(0, th - 1));
				end
				sample_pixel(col, row);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.cmd <= CMD_LOAD;
		req.col <= '0;
		req.row <= '0;
		req.pixel_in <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SRC_WIDTH;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_LOAD, 12'd0, 12'd0, 32'h0000_0000);
		send_item(CMD_LOAD, 12'd255, 12'd255, 32'hFFFF_FFFF);
		send_item(CMD_LOAD, 12'd255, 12'd0, 32'hA5A5_A5A5);
		send_item(CMD_LOAD, 12'd0, 12'd255, 32'h5A5A_5A5A);
		send_item(CMD_LOAD, 12'd256, 12'd0, 32'h1234_5678);
		send_item(CMD_LOAD, 12'd0, 12'd256, 32'h8765_4321);
		send_item(CMD_LOAD, 12'd4095, 12'd4095, 32'hDEAD_BEEF);
		sample_pixel(12'd0, 12'd0);
		sample_pixel(12'd255, 12'd255);
		sample_pixel(12'd255, 12'd0);
		sample_pixel(12'd0, 12'd255);
		sample_pixel(12'd4095, 12'd4095);
		sample_pixel(12'd4095, 12'd0);
		sample_pixel(12'd256, 12'd256);
		sample_pixel(12'd0, 12'd1);
		sample_pixel(12'd1, 12'd0);

		set_sizes(13'd1, 13'd1, 13'd1, 13'd1);
		random_items(60);
		set_sizes(13'd0, 13'd0, 13'd0, 13'd0);
		random_items(60);
		set_sizes(13'd3, 13'd5, 13'd7, 13'd2);
		random_items(120);
		set_sizes(13'd256, 13'd256, 13'd4096, 13'd4096);
		stall_en = 1'b0;
		random_items(120);
		stall_en = 1'b1;
		set_sizes(13'h1FFF, 13'd300, 13'd8191, 13'd8191);
		random_items(80);
		set_sizes(13'd256, 13'd256, 13'd1, 13'd1);
		random_items(80);
		set_sizes(13'h1E03, 13'h0A05, 13'd9, 13'd11);
		random_items(100);
		set_sizes(13'd2, 13'd2, 13'd4096, 13'd3);
		random_items(100);
		set_sizes(13'd5, 13'd7, 13'd0, 13'd8191);
		random_items(100);
		set_sizes(13'd16, 13'd12, 13'd40, 13'd25);
		random_items(90);
		repeat (5) begin
			set_sizes(13'($urandom_range(1, 40)), 13'($urandom_range(1, 40)),
				13'($urandom_range(1, 100)), 13'($urandom_range(1, 100)));
			random_items(50);
		end

		settle();
		if (sb.errors == 0 && sb.expected_pixels.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
